@@ rtl/cpes_pkg.sv @@
package cpes_pkg;

    // Default sizes of the delay store and the quarter-wave sine table.
    localparam int DELAY_DEPTH_DEF     = 16384;
    localparam int SINE_TABLE_BITS_DEF = 10;

    // Field widths.
    localparam int STEP_W   = 32;
    localparam int LENGTH_W = 16;
    localparam int GAIN_W   = 15;
    localparam int DELAY_W  = 15;
    localparam int SAMPLE_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_START_STEP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SLOPE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PING_LENGTH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TONE_AMPLITUDE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_DECAY     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_DELAY     = 3'd5;

    // Register values after reset.
    localparam logic [STEP_W-1:0]   START_STEP_RST     = '0;
    localparam logic [STEP_W-1:0]   STEP_SLOPE_RST     = '0;
    localparam logic [LENGTH_W-1:0] PING_LENGTH_RST    = 16'd12000;
    localparam logic [GAIN_W-1:0]   TONE_AMPLITUDE_RST = 15'd16384;
    localparam logic [GAIN_W-1:0]   ECHO_DECAY_RST     = 15'd16384;
    localparam logic [DELAY_W-1:0]  ECHO_DELAY_RST     = 15'd16384;

    // Q30 Taylor coefficients of sin(pi/2 * t).
    localparam longint Q30_ONE = 64'sd1073741824;
    localparam longint HALF_Q30 = 64'sd536870912;
    localparam longint COEF_1 = 64'sd1686629713;
    localparam longint COEF_3 = -64'sd693598669;
    localparam longint COEF_5 = 64'sd85569306;
    localparam longint COEF_7 = -64'sd5026995;
    localparam longint COEF_9 = 64'sd172271;

    // One quarter-wave table entry, evaluated at elaboration time only.
    function automatic logic [GAIN_W-1:0] sine_entry(input int k, input int bits);
        longint t;
        longint t2;
        longint p;
        begin
            t  = longint'(2 * k + 1) <<< (29 - bits);
            t2 = (t * t) / Q30_ONE;
            p  = COEF_7 + (t2 * COEF_9) / Q30_ONE;
            p  = COEF_5 + (t2 * p) / Q30_ONE;
            p  = COEF_3 + (t2 * p) / Q30_ONE;
            p  = COEF_1 + (t2 * p) / Q30_ONE;
            p  = (t * p) / Q30_ONE;
            if (p < 0)
            begin
                p = 0;
            end
            p = (p * 64'sd32767 + HALF_Q30) / Q30_ONE;
            if (p > 64'sd32767)
            begin
                p = 64'sd32767;
            end
            return p[GAIN_W-1:0];
        end
    endfunction

endpackage

@@ rtl/chirp_ping_echo_synth_core.sv @@
// Items pass stages s1, s2, s3 and e to the output register. Throughput: one
// item per cycle unless stalled; the read-modify-write of the echo delay store
// closes in a single stage, with the read forwarded from the write in flight.
// Reset: asynchronous, active low; registers take their default values at once.
// The delay store is not swept: a fill count marks written entries, and entries
// beyond it read as zero, so items are accepted right after reset.
module chirp_ping_echo_synth_core #(
    parameter int DELAY_DEPTH     = cpes_pkg::DELAY_DEPTH_DEF,
    parameter int SINE_TABLE_BITS = cpes_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [cpes_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [cpes_pkg::CFG_DATA_W-1:0]      cfg_data,

    input  logic                                 tick_valid,
    output logic                                 tick_stall,
    input  logic                                 start_req,

    output logic                                 sample_valid,
    input  logic                                 sample_stall,
    output logic signed [cpes_pkg::SAMPLE_W-1:0] sample,
    output logic                                 active
);

    localparam int PW = $clog2(DELAY_DEPTH);
    localparam int CW = (PW + 1 > cpes_pkg::DELAY_W) ? PW + 1 : cpes_pkg::DELAY_W;
    localparam int SB = SINE_TABLE_BITS;
    localparam int N  = 1 << SINE_TABLE_BITS;
    localparam int GW = cpes_pkg::GAIN_W;
    localparam int SW = cpes_pkg::SAMPLE_W;
    localparam logic [PW:0] DEPTH_VAL = (PW + 1)'(DELAY_DEPTH);

    // Configuration registers.
    logic [cpes_pkg::STEP_W-1:0]   start_step_reg;
    logic [cpes_pkg::STEP_W-1:0]   step_slope_reg;
    logic [cpes_pkg::LENGTH_W-1:0] ping_length_reg;
    logic [GW-1:0]                 tone_amplitude_reg;
    logic [GW-1:0]                 echo_decay_reg;
    logic [cpes_pkg::DELAY_W-1:0]  echo_delay_reg;

    // Per-tick state.
    logic [cpes_pkg::STEP_W-1:0]   phase_reg, phase_next;
    logic [cpes_pkg::STEP_W-1:0]   step_reg, step_next;
    logic [cpes_pkg::LENGTH_W-1:0] left_reg, left_next;
    logic                          playing_reg, playing_next;
    logic [PW-1:0]                 pos_reg, pos_next;
    logic [PW:0]                   fill_reg;

    // Pipeline stages.
    logic          s1_v_reg, s2_v_reg, s3_v_reg, e_v_reg, out_v_reg;
    logic          s1_idle_reg, s1_tone_reg, s1_neg_reg, s1_active_reg;
    logic [SB-1:0] s1_k_reg;
    logic [PW-1:0] s1_pos_reg;
    logic          s2_idle_reg, s2_tone_reg, s2_neg_reg, s2_active_reg;
    logic [GW-1:0] s2_entry_reg;
    logic [PW-1:0] s2_pos_reg;
    logic          s3_idle_reg, s3_active_reg;
    logic signed [SW-1:0] s3_tone_reg;
    logic [PW-1:0] s3_pos_reg;
    logic          e_idle_reg, e_active_reg, e_fwd_reg, e_zero_reg;
    logic signed [SW-1:0] e_tone_reg, e_fwd_data_reg, e_rd_data_reg;
    logic [PW-1:0] e_pos_reg;
    logic signed [SW-1:0] sample_reg;
    logic          active_reg;

    logic [SW-1:0] echo_mem [DELAY_DEPTH];
    logic [GW-1:0] sine_rom [N];

    logic accept;
    logic out_free, e_free, s3_free, s2_free, s1_free;
    logic e_adv, s3_adv, s2_adv, s1_adv;
    logic start_now, play_now, tone_now;
    logic [cpes_pkg::STEP_W-1:0]   step_use;
    logic [cpes_pkg::LENGTH_W-1:0] left_use;
    logic [cpes_pkg::STEP_W-1:0]   phase_adv;
    logic [SB-1:0]                 k_raw;
    logic [PW:0]                   pos_inc;
    logic                          pos_wrap;
    logic [2*GW-1:0]               tone_prod;
    logic [GW-1:0]                 tone_mag;
    logic signed [SW-1:0]          tone_signed;
    logic signed [SW-1:0]          echo_val;
    logic signed [31:0]            echo_prod;
    logic signed [31:0]            echo_shift;
    logic signed [SW+1:0]          mix_sum;
    logic signed [SW-1:0]          mix_sat;
    logic                          wr_en;
    logic                          rd_fwd;
    logic                          rd_zero;

    for (genvar i = 0; i < N; i++)
    begin : g_sine
        localparam logic [GW-1:0] ENTRY = cpes_pkg::sine_entry(i, SINE_TABLE_BITS);
        assign sine_rom[i] = ENTRY;
    end

    assign cfg_ready = 1'b1;

    // Stage handshake: a stage moves on when the next one is empty or moving.
    assign out_free   = !out_v_reg || !sample_stall;
    assign e_free     = !e_v_reg || out_free;
    assign s3_free    = !s3_v_reg || e_free;
    assign s2_free    = !s2_v_reg || s3_free;
    assign s1_free    = !s1_v_reg || s2_free;
    assign e_adv      = e_v_reg && out_free;
    assign s3_adv     = s3_v_reg && e_free;
    assign s2_adv     = s2_v_reg && s3_free;
    assign s1_adv     = s1_v_reg && s2_free;
    assign tick_stall = !s1_free;
    assign accept     = tick_valid && s1_free;

    assign sample_valid = out_v_reg;
    assign sample       = sample_reg;
    assign active       = active_reg;

    // Tick state update for the item being accepted.
    always_comb
    begin
        start_now    = start_req && !playing_reg;
        play_now     = playing_reg || start_req;
        step_use     = start_now ? start_step_reg : step_reg;
        left_use     = start_now ? ping_length_reg : left_reg;
        tone_now     = play_now && (left_use != '0);
        phase_adv    = phase_reg + step_use;
        k_raw        = phase_adv[29 -: SB];
        pos_inc      = {1'b0, pos_reg} + 1'b1;
        pos_wrap     = (pos_inc >= DEPTH_VAL) ||
                       (CW'(pos_inc) >= CW'(echo_delay_reg));

        phase_next   = phase_reg;
        step_next    = step_reg;
        left_next    = left_reg;
        playing_next = playing_reg;
        pos_next     = pos_reg;
        if (play_now)
        begin
            pos_next  = pos_wrap ? '0 : pos_inc[PW-1:0];
            left_next = left_use;
            step_next = step_use;
            if (tone_now)
            begin
                phase_next   = phase_adv;
                step_next    = step_use + step_slope_reg;
                left_next    = left_use - 1'b1;
                playing_next = 1'b1;
            end
            else
            begin
                playing_next = 1'b0;
            end
        end
    end

    // Tone magnitude and sign.
    assign tone_prod   = s2_entry_reg * tone_amplitude_reg;
    assign tone_mag    = s2_tone_reg ? tone_prod[2*GW-1:GW] : '0;
    assign tone_signed = s2_neg_reg ? -$signed({1'b0, tone_mag}) : $signed({1'b0, tone_mag});

    // Echo mix; the product is divided by 2^15 rounding toward zero.
    always_comb
    begin
        if (e_fwd_reg)
        begin
            echo_val = e_fwd_data_reg;
        end
        else if (e_zero_reg)
        begin
            echo_val = '0;
        end
        else
        begin
            echo_val = e_rd_data_reg;
        end
        echo_prod  = 32'(echo_val) * $signed({17'b0, echo_decay_reg});
        echo_shift = echo_prod[31] ? ((echo_prod + 32'sd32767) >>> 15) : (echo_prod >>> 15);
        mix_sum    = (SW + 2)'(e_tone_reg) + echo_shift[SW+1:0];
        if (mix_sum > (SW + 2)'(32767))
        begin
            mix_sat = 16'sh7FFF;
        end
        else if (mix_sum < -(SW + 2)'(32768))
        begin
            mix_sat = 16'sh8000;
        end
        else
        begin
            mix_sat = mix_sum[SW-1:0];
        end
    end

    assign wr_en   = e_adv && !e_idle_reg;
    assign rd_fwd  = wr_en && (e_pos_reg == s3_pos_reg);
    assign rd_zero = ({1'b0, s3_pos_reg} >= fill_reg);

    // Configuration, tick state and stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_step_reg     <= cpes_pkg::START_STEP_RST;
            step_slope_reg     <= cpes_pkg::STEP_SLOPE_RST;
            ping_length_reg    <= cpes_pkg::PING_LENGTH_RST;
            tone_amplitude_reg <= cpes_pkg::TONE_AMPLITUDE_RST;
            echo_decay_reg     <= cpes_pkg::ECHO_DECAY_RST;
            echo_delay_reg     <= cpes_pkg::ECHO_DELAY_RST;
            phase_reg          <= '0;
            step_reg           <= '0;
            left_reg           <= '0;
            playing_reg        <= 1'b0;
            pos_reg            <= '0;
            fill_reg           <= '0;
            s1_v_reg           <= 1'b0;
            s2_v_reg           <= 1'b0;
            s3_v_reg           <= 1'b0;
            e_v_reg            <= 1'b0;
            out_v_reg          <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    cpes_pkg::CFG_START_STEP:     start_step_reg     <= cfg_data;
                    cpes_pkg::CFG_STEP_SLOPE:     step_slope_reg     <= cfg_data;
                    cpes_pkg::CFG_PING_LENGTH:    ping_length_reg    <= cfg_data[15:0];
                    cpes_pkg::CFG_TONE_AMPLITUDE: tone_amplitude_reg <= cfg_data[14:0];
                    cpes_pkg::CFG_ECHO_DECAY:     echo_decay_reg     <= cfg_data[14:0];
                    cpes_pkg::CFG_ECHO_DELAY:     echo_delay_reg     <= cfg_data[14:0];
                    default:
                    begin
                    end
                endcase
            end
            if (accept)
            begin
                phase_reg   <= phase_next;
                step_reg    <= step_next;
                left_reg    <= left_next;
                playing_reg <= playing_next;
                pos_reg     <= pos_next;
            end
            if (wr_en && ({1'b0, e_pos_reg} == fill_reg))
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            if (s1_free)
            begin
                s1_v_reg <= accept;
            end
            if (s2_free)
            begin
                s2_v_reg <= s1_v_reg;
            end
            if (s3_free)
            begin
                s3_v_reg <= s2_v_reg;
            end
            if (e_free)
            begin
                e_v_reg <= s3_v_reg;
            end
            if (out_free)
            begin
                out_v_reg <= e_v_reg;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_idle_reg   <= !play_now;
            s1_tone_reg   <= tone_now;
            s1_neg_reg    <= phase_adv[31];
            s1_k_reg      <= phase_adv[30] ? ~k_raw : k_raw;
            s1_pos_reg    <= pos_reg;
            s1_active_reg <= tone_now;
        end
        if (s1_adv)
        begin
            s2_idle_reg   <= s1_idle_reg;
            s2_tone_reg   <= s1_tone_reg;
            s2_neg_reg    <= s1_neg_reg;
            s2_entry_reg  <= sine_rom[s1_k_reg];
            s2_pos_reg    <= s1_pos_reg;
            s2_active_reg <= s1_active_reg;
        end
        if (s2_adv)
        begin
            s3_idle_reg   <= s2_idle_reg;
            s3_tone_reg   <= tone_signed;
            s3_pos_reg    <= s2_pos_reg;
            s3_active_reg <= s2_active_reg;
        end
        if (s3_adv)
        begin
            e_idle_reg     <= s3_idle_reg;
            e_tone_reg     <= s3_tone_reg;
            e_pos_reg      <= s3_pos_reg;
            e_active_reg   <= s3_active_reg;
            e_fwd_reg      <= rd_fwd;
            e_fwd_data_reg <= mix_sat;
            e_zero_reg     <= rd_zero;
        end
        if (e_adv)
        begin
            sample_reg <= e_idle_reg ? '0 : mix_sat;
            active_reg <= e_active_reg;
        end
    end

    // Echo delay store: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            echo_mem[e_pos_reg] <= mix_sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_adv)
        begin
            e_rd_data_reg <= echo_mem[s3_pos_reg];
        end
    end

endmodule
